// ----- rtl/core/celacc_pkg.sv -----
`timescale 1ns / 1ps
package celacc_pkg;
    localparam int MAX_EVENTS_DEF = 4096;
    localparam int FRAC_BITS_DEF  = 4;
    localparam int DIV_W = 24;
    localparam int SQ_W  = 48;
    localparam logic [2:0] CFG_CX = 3'd0;
    localparam logic [2:0] CFG_CY = 3'd1;
    localparam logic [2:0] CFG_R  = 3'd2;
    localparam logic [2:0] CFG_CW = 3'd3;
    localparam logic [2:0] CFG_PW = 3'd4;
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_CONCLUDE = 1'b1;
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_unit_ctl;
endpackage

// ----- rtl/core/celacc_div.sv -----
`timescale 1ns / 1ps
module celacc_div import celacc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DIV_W-1:0] i_num,
    input  logic [16:0]             i_den,
    output logic                    o_busy,
    output logic                    o_done,
    output logic signed [DIV_W-1:0] o_quo
);
    logic [DIV_W-1:0] r_q;
    logic [17:0]      r_rem;
    logic [4:0]       r_cnt;
    logic             r_neg;
    logic             r_busy;
    logic             r_done;
    logic [17:0]      n_trial;
    logic [18:0]      n_sh;

    always_comb begin
        n_sh    = {r_rem, r_q[DIV_W-1]};
        n_trial = n_sh[17:0] - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_rem  <= '0;
                r_neg  <= i_num[DIV_W-1];
                r_q    <= i_num[DIV_W-1] ? DIV_W'(-i_num) : i_num;
            end else if (r_busy) begin
                if (n_sh[18:0] >= {2'b0, i_den}) begin
                    r_rem <= n_trial;
                    r_q   <= {r_q[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_sh[17:0];
                    r_q   <= {r_q[DIV_W-2:0], 1'b0};
                end
                if (r_cnt == 5'(DIV_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_neg ? DIV_W'(-r_q) : r_q;
endmodule

// ----- rtl/core/celacc_sqrt.sv -----
`timescale 1ns / 1ps
module celacc_sqrt import celacc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SQ_W-1:0] i_val,
    output logic            o_done,
    output logic [SQ_W/2-1:0] o_root
);
    logic [SQ_W-1:0]   r_v;
    logic [SQ_W-1:0]   r_res;
    logic [SQ_W-1:0]   r_bit;
    logic              r_busy;
    logic              r_done;
    logic [SQ_W-1:0]   n_sum;

    assign n_sum = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_v    <= i_val;
                r_res  <= '0;
                r_bit  <= {2'b01, {(SQ_W-2){1'b0}}};
            end else if (r_busy) begin
                if (r_v >= n_sum) begin
                    r_v   <= r_v - n_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_root = r_res[SQ_W/2-1:0];
endmodule

// ----- rtl/core/circle_event_likelihood_accumulator.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Signals
// s_axis  | in        | tdata = {event_age, event_y, event_x}, tuser = cmd
// m_axis  | out       | tdata = {new_weight, new_window, accepted, score}
// cfg     | in        | i_cfg_we, i_cfg_idx, i_cfg_data
// An event that passes the square test with enough inliers steps through classify, update and
// the inlier count check, two 24-step divisions on one shared divider, a 24-step square root
// and a compare. An event outside the square stops after classify, one with too few inliers
// after the inlier check; a conclude goes straight to the output state.
// Reset is synchronous and clears all control state and accumulators.
// The result register holds while m_axis_tready is low; no transaction is taken then.
module circle_event_likelihood_accumulator import celacc_pkg::*; #(
    parameter int MAX_EVENTS = MAX_EVENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // event_x, event_y, event_age, pad
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // score, accepted, new_window, new_weight, pad
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    localparam int CW = $clog2(MAX_EVENTS+1);
    localparam int HW = CW + 1;
    localparam int FRAC_BITS = FRAC_BITS_DEF;
    localparam int VW = HW + FRAC_BITS + 12;
    typedef enum logic [2:0] {S_IDLE, S_CLS, S_UPD, S_DIVX, S_DIVY, S_SQRT, S_CMP, S_OUT}
        t_state;
    t_state r_state;

    logic signed [12:0] r_cx, r_cy;
    logic [9:0]  r_rad;
    logic [23:0] r_cw;
    logic [15:0] r_pw;
    logic signed [HW-1:0] r_hit;
    logic [CW-1:0] r_inl;
    logic signed [23:0] r_sx, r_sy, r_mx;
    logic [16:0] r_best;
    logic [23:0] r_bwin, r_age;
    logic signed [14:0] r_dx, r_dy;
    logic [6:0] r_ex, r_ey;
    logic [71:0] r_out;
    logic r_ov;
    logic signed [31:0] r_d2;

    logic signed [15:0] w_ex, w_ey;
    logic signed [14:0] w_dx, w_dy;
    logic [14:0] w_ax, w_ay;
    logic signed [15:0] w_r, w_rp2, w_rm2, w_rm4;
    logic w_in, w_mid, w_over;
    logic signed [HW+1:0] w_hadd;
    logic signed [24:0] w_sx, w_sy;
    logic signed [VW-1:0] w_val;
    logic [16:0] w_sc;
    logic w_acc;
    logic [47:0] w_sq;
    logic div_start, sq_start, div_done, div_busy, sq_done;
    logic signed [23:0] div_num, div_q;
    logic [23:0] sq_root;
    logic signed [HW+FRAC_BITS+24:0] w_inlsh;

    assign w_ex = 16'(r_ex) <<< FRAC_BITS;
    assign w_ey = 16'(r_ey) <<< FRAC_BITS;
    assign w_dx = 15'(w_ex - 16'(r_cx));
    assign w_dy = 15'(w_ey - 16'(r_cy));
    assign w_ax = w_dx[14] ? 15'(-w_dx) : w_dx;
    assign w_ay = w_dy[14] ? 15'(-w_dy) : w_dy;
    assign w_r   = 16'(r_rad);
    assign w_rp2 = w_r + (16'sd2 <<< FRAC_BITS);
    assign w_rm2 = w_r - (16'sd2 <<< FRAC_BITS);
    assign w_rm4 = w_r - (16'sd4 <<< FRAC_BITS);
    assign w_over = (16'(w_ax) > w_rp2) || (16'(w_ay) > w_rp2);
    assign w_in  = (r_d2 < 32'(w_rp2) * 32'(w_rp2)) &&
                   (w_rm2 < 0 || r_d2 > 32'(w_rm2) * 32'(w_rm2));
    assign w_mid = (w_rm4 < 0 || r_d2 > 32'(w_rm4) * 32'(w_rm4)) && w_rm2 >= 0 &&
                   r_d2 <= 32'(w_rm2) * 32'(w_rm2);
    assign w_inlsh = (HW+FRAC_BITS+25)'(r_inl) <<< FRAC_BITS;
    assign div_num = (r_state == S_DIVX) ? r_sx : r_sy;
    assign w_sq = 48'(r_mx * r_mx) + 48'(div_q * div_q);
    assign w_val = (VW'(r_hit) <<< FRAC_BITS) - $signed(VW'(sq_root));
    assign w_acc = !(r_best == 17'd0 || w_inlsh < (HW+FRAC_BITS+25)'(r_rad));
    assign w_sc  = w_acc ? r_best : 17'd16;

    always_comb begin
        w_hadd = (HW+2)'(r_hit) + (w_in ? (HW+2)'(1) : -(HW+2)'(3));
        if (w_hadd > (HW+2)'(MAX_EVENTS)) w_hadd = (HW+2)'(MAX_EVENTS);
        if (w_hadd < -(HW+2)'(MAX_EVENTS)) w_hadd = -(HW+2)'(MAX_EVENTS);
        w_sx = 25'(r_sx) + 25'(r_dx);
        w_sy = 25'(r_sy) + 25'(r_dy);
        if (w_sx > 25'sd8388607) w_sx = 25'sd8388607;
        if (w_sx < -25'sd8388608) w_sx = -25'sd8388608;
        if (w_sy > 25'sd8388607) w_sy = 25'sd8388607;
        if (w_sy < -25'sd8388608) w_sy = -25'sd8388608;
    end

    celacc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(17'(r_inl)), .o_busy(div_busy), .o_done(div_done), .o_quo(div_q)
    );
    celacc_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_val(w_sq),
        .o_done(sq_done), .o_root(sq_root)
    );

    logic r_go;
    assign div_start = r_go && (r_state == S_DIVX || r_state == S_DIVY);
    assign sq_start  = r_go && r_state == S_SQRT;

    assign s_axis_tready = (r_state == S_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go <= 1'b0;
            r_ov <= 1'b0;
            r_cx <= 13'sd1024; r_cy <= 13'sd1024; r_rad <= 10'd160;
            r_cw <= 24'd50000; r_pw <= 16'hFFFF;
            r_hit <= '0; r_inl <= '0; r_sx <= '0; r_sy <= '0;
            r_best <= '0; r_bwin <= '0;
        end else begin
            r_go <= 1'b0;
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CX: r_cx <= i_cfg_data[12:0];
                    CFG_CY: r_cy <= i_cfg_data[12:0];
                    CFG_R:  r_rad <= i_cfg_data[9:0];
                    CFG_CW: r_cw <= i_cfg_data;
                    CFG_PW: r_pw <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_ex <= s_axis_tdata[6:0];
                        r_ey <= s_axis_tdata[13:7];
                        r_age <= s_axis_tdata[37:14];
                        r_state <= (s_axis_tuser == CMD_CONCLUDE) ? S_OUT : S_CLS;
                    end
                end
                S_CLS: begin
                    r_dx <= w_dx; r_dy <= w_dy;
                    r_d2 <= 32'(w_dx * w_dx) + 32'(w_dy * w_dy);
                    r_state <= w_over ? S_IDLE : S_UPD;
                end
                S_UPD: begin
                    if (w_in || w_mid) r_hit <= HW'(w_hadd);
                    if (w_in && r_inl < CW'(MAX_EVENTS)) begin
                        r_inl <= r_inl + 1'b1;
                        r_sx <= 24'(w_sx); r_sy <= 24'(w_sy);
                    end
                    r_state <= S_DIVX;
                end
                S_DIVX: begin
                    if (div_done) begin
                        r_mx <= div_q; r_state <= S_DIVY; r_go <= 1'b1;
                    end else if (!r_go && !div_busy) begin
                        if (r_inl == '0 || w_inlsh <= (HW+FRAC_BITS+25)'(r_rad))
                            r_state <= S_IDLE;
                        else
                            r_go <= 1'b1;
                    end
                end
                S_DIVY: if (div_done) begin r_state <= S_SQRT; r_go <= 1'b1; end
                S_SQRT: if (sq_done) r_state <= S_CMP;
                S_CMP: begin
                    if (w_val > $signed(VW'(r_best))) begin
                        r_best <= (w_val > VW'(65536)) ? 17'd65536 : 17'(w_val);
                        r_bwin <= r_age;
                    end
                    r_state <= S_IDLE;
                end
                S_OUT: begin
                    r_out <= {1'b0, 29'((33'(w_sc) * 33'(r_pw)) >> 4),
                              w_acc ? r_bwin : r_cw, w_acc, w_sc};
                    r_ov <= 1'b1;
                    r_hit <= '0; r_inl <= '0; r_sx <= '0; r_sy <= '0;
                    r_best <= '0; r_bwin <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov && $stable(r_out))
        else $error("result lost while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inl <= CW'(MAX_EVENTS)) else $error("inlier count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best <= 17'd65536) else $error("best score overflow");
endmodule

// ----- tb/sv/celacc_checker.sv -----
`timescale 1ns / 1ps
module celacc_checker import celacc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [23:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    localparam longint MAXEV = MAX_EVENTS_DEF;
    localparam int     FB = FRAC_BITS_DEF;
    localparam longint SUM_HI = (64'sd1 <<< 23) - 1;
    localparam longint SUM_LO = -(64'sd1 <<< 23);

    typedef struct packed {
        logic [28:0] weight;
        logic [23:0] window;
        logic        accepted;
        logic [16:0] score;
    } t_conclusion;

    t_conclusion expected_q[$];

    longint cx, cy, rad, cur_win, prior_w;
    longint hits, inliers, sum_x, sum_y, best, best_win;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v)
            bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end else begin
                res = res >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic bit beyond(longint d2, longint b);
        return b < 0 || d2 > b * b;
    endfunction

    task automatic clear_pass();
        hits = 0;
        inliers = 0;
        sum_x = 0;
        sum_y = 0;
        best = 0;
        best_win = 0;
    endtask

    task automatic score_event(logic [6:0] ex, logic [6:0] ey, logic [23:0] age);
        longint two, four, dx, dy, ax, ay, d2, mx, my, mag, val;
        two = 64'sd2 <<< FB;
        four = 64'sd4 <<< FB;
        dx = (longint'(ex) <<< FB) - cx;
        dy = (longint'(ey) <<< FB) - cy;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax > rad + two || ay > rad + two)
            return;
        d2 = dx * dx + dy * dy;
        if (d2 < (rad + two) * (rad + two) && beyond(d2, rad - two)) begin
            hits = clamp(hits + 1, -MAXEV, MAXEV);
            if (inliers < MAXEV) begin
                inliers++;
                sum_x = clamp(sum_x + dx, SUM_LO, SUM_HI);
                sum_y = clamp(sum_y + dy, SUM_LO, SUM_HI);
            end
        end else if (beyond(d2, rad - four) && rad - two >= 0 &&
                     d2 <= (rad - two) * (rad - two)) begin
            hits = clamp(hits - 3, -MAXEV, MAXEV);
        end
        if (inliers > 0 && (inliers <<< FB) > rad) begin
            mx = sum_x / inliers;
            my = sum_y / inliers;
            mag = floor_sqrt(mx * mx + my * my);
            val = hits * (64'sd1 <<< FB) - mag;
            if (val > best) begin
                best = val > 65536 ? 65536 : val;
                best_win = age;
            end
        end
    endtask

    function automatic t_conclusion conclude_pass();
        t_conclusion c;
        longint sc;
        if (best <= 0 || (inliers <<< FB) < rad) begin
            sc = 16;
            c.accepted = 1'b0;
            c.window = cur_win[23:0];
        end else begin
            sc = best;
            c.accepted = 1'b1;
            c.window = best_win[23:0];
        end
        c.score = sc[16:0];
        c.weight = 29'((sc * prior_w) >>> 4);
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_conclusion got, want;
        if (!i_rst_n) begin
            cx = 1024;
            cy = 1024;
            rad = 160;
            cur_win = 50000;
            prior_w = 65535;
            clear_pass();
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_CX: cx = longint'($signed(cfg_data[12:0]));
                    CFG_CY: cy = longint'($signed(cfg_data[12:0]));
                    CFG_R:  rad = longint'(cfg_data[9:0]);
                    CFG_CW: cur_win = longint'(cfg_data);
                    CFG_PW: prior_w = longint'(cfg_data[15:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_CONCLUDE) begin
                    expected_q.push_back(conclude_pass());
                    clear_pass();
                end else begin
                    score_event(s_tdata[6:0], s_tdata[13:7], s_tdata[37:14]);
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[70:0];
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction: %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"result mismatch: exp score %0d acc %0d win %0d wt %0d,",
                                      " got score %0d acc %0d win %0d wt %0d"},
                                     want.score, want.accepted, want.window, want.weight,
                                     got.score, got.accepted, got.window, got.weight);
                    end
                end
            end
        end
        pending = expected_q.size();
    end
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top import celacc_pkg::*; ();

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int stall_mode = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int cx_now = 1024;
    int cy_now = 1024;
    int rad_now = 160;

    always #1 i_clk = ~i_clk;

    circle_event_likelihood_accumulator dut (.*);

    celacc_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
        .cfg_we(i_cfg_we), .cfg_idx(i_cfg_idx), .cfg_data(i_cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge i_clk) begin
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 9) > 6);
        endcase
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic push_item(logic cmd, logic [6:0] ex, logic [6:0] ey, logic [23:0] age);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {2'b00, age, ey, ex};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 24'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic ring_event(logic [23:0] age);
        int span, px, py;
        span = rad_now / 16 + 3;
        px = (cx_now >>> 4) + $urandom_range(0, 2 * span) - span;
        py = (cy_now >>> 4) + $urandom_range(0, 2 * span) - span;
        push_item(CMD_EVENT, 7'(px), 7'(py), age);
    endtask

    initial begin
        int cmax;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_item(CMD_CONCLUDE, 7'd127, 7'd127, 24'hFFFFFF);
        push_item(CMD_EVENT, 7'd64, 7'd64, 24'd5);
        push_item(CMD_EVENT, 7'd71, 7'd64, 24'd6);
        push_item(CMD_EVENT, 7'd127, 7'd127, 24'hFFFFFF);
        push_item(CMD_EVENT, 7'd0, 7'd0, 24'd0);
        push_item(CMD_EVENT, 7'd74, 7'd64, 24'd7);
        push_item(CMD_CONCLUDE, 7'd0, 7'd0, 24'd0);
        for (int k = 0; k < 12; k++) begin
            push_item(CMD_EVENT, (k % 4 == 0) ? 7'd74 : (k % 4 == 1) ? 7'd54 : 7'd64,
                      (k % 4 == 2) ? 7'd74 : (k % 4 == 3) ? 7'd54 : 7'd64, 24'(100 + k));
        end
        push_item(CMD_CONCLUDE, 7'd0, 7'd0, 24'd0);
        drain();

        for (int ph = 0; ph < 11; ph++) begin
            stall_mode = ph % 3;
            case (ph)
                0: begin cx_now = -2048; cy_now = 4095; rad_now = 576; end
                1: begin cx_now = 1024; cy_now = 1024; rad_now = 0; end
                2: begin cx_now = 1030; cy_now = 1000; rad_now = 1023; end
                3: begin cx_now = 300; cy_now = 1800; rad_now = 160; end
                default: begin
                    rad_now = $urandom_range(160, 576);
                    cmax = 2047 - rad_now;
                    cx_now = $urandom_range(rad_now, cmax);
                    cy_now = $urandom_range(rad_now, cmax);
                end
            endcase
            write_reg(CFG_CX, cx_now);
            write_reg(CFG_CY, cy_now);
            write_reg(CFG_R, rad_now);
            write_reg(CFG_CW, (ph == 0) ? 24'hFFFFFF : (ph == 1) ? 0 : $urandom());
            write_reg(CFG_PW, (ph == 0) ? 16'hFFFF : (ph == 1) ? 0 : $urandom_range(0, 65535));
            for (int n = 0; n < 95;) begin
                int pass_len;
                pass_len = $urandom_range(5, 70);
                for (int k = 0; k < pass_len && n < 95; k++, n++) begin
                    if ($urandom_range(0, 9) == 0)
                        push_item(CMD_EVENT, 7'($urandom()), 7'($urandom()), 24'($urandom()));
                    else
                        ring_event(24'($urandom()));
                end
                push_item(CMD_CONCLUDE, 7'($urandom()), 7'($urandom()), 24'($urandom()));
                n++;
            end
            drain();
        end

        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/celacc_pkg.sv
rtl/core/celacc_div.sv
rtl/core/celacc_sqrt.sv
rtl/core/circle_event_likelihood_accumulator.sv
tb/sv/celacc_checker.sv
tb/sv/tb_top.sv
